// ----- hw/rtl/frw_pkg.sv -----
// Package for the fragment reassembly writer: constants, beat types and state record.
package frw_pkg;

  localparam int unsigned BUFFER_BYTES    = 1048576;
  localparam int unsigned FRAGMENT_STRIDE = 1024;
  localparam int unsigned MAX_FRAGMENTS   = 255;
  localparam int unsigned HEADER_BYTES    = 8;

  // Append pointer must hold the buffer size itself.
  localparam int unsigned APPEND_W = $clog2(BUFFER_BYTES + 1);
  // Wide enough for 255 * 65535 + 65535 and for the buffer size.
  localparam int unsigned SUM_W    = 25;
  localparam int unsigned ADDR_W   = 20;

  localparam logic [7:0] CH_OPEN_BRACE    = 8'h7B;
  localparam logic [7:0] CH_OPEN_BRACKET  = 8'h5B;
  localparam logic [7:0] CH_CLOSE_BRACE   = 8'h7D;
  localparam logic [7:0] CH_CLOSE_BRACKET = 8'h5D;

  localparam logic       MODE_DATA  = 1'b0;
  localparam logic       MODE_BEGIN = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_INCOMPLETE = 2'd1;
  localparam logic [1:0] STATUS_SHORT      = 2'd2;

  localparam logic [8:0] RCV_FRAG_MAX = 9'd511;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_data;
    logic              packet_end;
    logic              complete;
    logic [1:0]        status;
    logic [31:0]       result_length;
  } out_beat_t;

  typedef struct packed {
    logic [15:0]         pos;
    logic [63:0]         hdr;
    logic [7:0]          exp_frag;
    logic [8:0]          rcv_frag;
    logic [31:0]         vlen;
    logic [APPEND_W-1:0] app;
    logic [15:0]         depth;
    logic                done;
  } frw_state_t;

  localparam frw_state_t STATE_RESET = '{
    pos:      '0,
    hdr:      '0,
    exp_frag: 8'(MAX_FRAGMENTS),
    rcv_frag: '0,
    vlen:     '0,
    app:      '0,
    depth:    '0,
    done:     1'b0
  };

endpackage

// ----- hw/rtl/fragment_reassembly_writer.sv -----
// Top level of the fragment reassembly writer: state, config register and result register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------
//   in      | input     | in_valid / in_ready    | in_data  (mode, byte, last flag)
//   out     | output    | out_valid / out_ready  | out_data (store and status)
//   cfg     | input     | cfg_write_enable       | cfg_write_data (image_transfer)
//
// Each accepted byte beat produces one result beat in the following cycle; one beat per
// clock is sustained while out_ready is high. The per-byte state update and the address
// compute (fragment index times stride plus offset) sit between the state registers and
// the result register. in_ready drops only while a result waits and out_ready is low.
// Reset loads STATE_RESET and selects text mode; no clearing pass is needed.
module fragment_reassembly_writer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  frw_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output frw_pkg::out_beat_t out_data,
  input  logic               cfg_write_enable,
  input  logic               cfg_write_data
);
  import frw_pkg::*;

  frw_state_t st_r;
  frw_state_t st_nxt;
  out_beat_t  res_nxt;
  out_beat_t  out_data_r;
  logic       out_valid_r;
  logic       image_r;
  logic       in_accept;

  frw_step u_step (
    .st             (st_r),
    .image_transfer (image_r),
    .beat           (in_data),
    .st_nxt         (st_nxt),
    .res            (res_nxt)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= STATE_RESET;
      image_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        image_r <= cfg_write_data;
      end
      if (in_accept) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

// ----- hw/rtl/frw_step.sv -----
// Next-state and result logic for one received byte.
module frw_step (
  input  frw_pkg::frw_state_t st,
  input  logic                image_transfer,
  input  frw_pkg::in_beat_t   beat,
  output frw_pkg::frw_state_t st_nxt,
  output frw_pkg::out_beat_t  res
);
  import frw_pkg::*;

  logic [63:0]         hdr_nxt;
  logic [7:0]          frag;
  logic [7:0]          total;
  logic [15:0]         dlen;
  logic [31:0]         ilen;
  logic                unfrag;
  logic                in_header;
  logic [15:0]         d;
  logic [SUM_W-1:0]    a;
  logic                keep;
  logic [16:0]         pos_inc;
  logic [16:0]         n;
  logic [31:0]         n_clip;
  logic [8:0]          rcv_inc;
  logic [7:0]          exp_nxt;
  logic [APPEND_W-1:0] app_nxt;
  logic [15:0]         depth_nxt;

  always_comb begin
    in_header = (st.pos < 16'(HEADER_BYTES));
    hdr_nxt   = in_header ? {st.hdr[55:0], beat.data_byte} : st.hdr;
    frag      = hdr_nxt[63:56];
    total     = hdr_nxt[55:48];
    dlen      = hdr_nxt[47:32];
    ilen      = hdr_nxt[31:0];
    unfrag    = (dlen == 16'd0) || (ilen == 32'd0);
    d         = st.pos - 16'(HEADER_BYTES);
    a         = unfrag ? SUM_W'(d)
                       : SUM_W'(frag) * SUM_W'(FRAGMENT_STRIDE) + SUM_W'(d);
    keep      = unfrag || (d < dlen);
    pos_inc   = {1'b0, st.pos} + 17'd1;
    n         = pos_inc - 17'(HEADER_BYTES);
    n_clip    = (32'(n) > 32'(BUFFER_BYTES)) ? 32'(BUFFER_BYTES) : 32'(n);
    rcv_inc   = (st.rcv_frag < RCV_FRAG_MAX) ? st.rcv_frag + 9'd1 : st.rcv_frag;
    exp_nxt   = (frag == 8'd0) ? total : st.exp_frag;
    app_nxt   = st.app;
    depth_nxt = st.depth;

    st_nxt = st;
    res    = '0;

    if (beat.mode == MODE_BEGIN) begin
      st_nxt = STATE_RESET;
    end else begin
      res.packet_end = beat.last_byte;
      if (!st.done) begin
        if (image_transfer) begin
          st_nxt.hdr = hdr_nxt;
          if (!in_header && keep && (a < SUM_W'(BUFFER_BYTES))) begin
            res.write_enable  = 1'b1;
            res.write_address = a[ADDR_W-1:0];
            res.write_data    = beat.data_byte;
          end
          if (beat.last_byte) begin
            if (pos_inc < 17'(HEADER_BYTES)) begin
              res.status = STATUS_SHORT;
            end else if (unfrag) begin
              st_nxt.vlen = n_clip;
              st_nxt.done = 1'b1;
            end else begin
              st_nxt.exp_frag = exp_nxt;
              st_nxt.rcv_frag = rcv_inc;
              if (rcv_inc == {1'b0, exp_nxt}) begin
                st_nxt.vlen = ilen;
                st_nxt.done = 1'b1;
              end else begin
                st_nxt.vlen = st.vlen + 32'(dlen);
              end
            end
          end
        end else begin
          if (st.app < APPEND_W'(BUFFER_BYTES)) begin
            res.write_enable  = 1'b1;
            res.write_address = st.app[ADDR_W-1:0];
            res.write_data    = beat.data_byte;
            app_nxt           = st.app + APPEND_W'(1);
            case (beat.data_byte) inside
              CH_OPEN_BRACE, CH_OPEN_BRACKET:   depth_nxt = st.depth + 16'd1;
              CH_CLOSE_BRACE, CH_CLOSE_BRACKET: depth_nxt = st.depth - 16'd1;
              default:                          depth_nxt = st.depth;
            endcase
          end
          st_nxt.app   = app_nxt;
          st_nxt.depth = depth_nxt;
          if (beat.last_byte) begin
            if (depth_nxt == 16'd0) begin
              st_nxt.vlen = 32'(app_nxt);
              st_nxt.done = 1'b1;
            end else begin
              res.status = STATUS_INCOMPLETE;
            end
          end
        end
        // restart offset at packet end, else saturate
        if (beat.last_byte) begin
          st_nxt.pos = '0;
        end else if (st.pos < POS_MAX) begin
          st_nxt.pos = pos_inc[15:0];
        end
      end
      res.complete      = st_nxt.done;
      res.result_length = st_nxt.vlen;
    end
  end

endmodule

// ----- dv/fragment_reassembly_writer_test.sv -----
// Testbench for the fragment reassembly writer: byte stimulus, store prediction and result checks.
module fragment_reassembly_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import frw_pkg::*;

  localparam int STALL_LIMIT = 2000;

  class store_scoreboard;
    logic        image_mode;
    logic [15:0] offset;
    logic [63:0] header_shift;
    logic [7:0]  frag_total;
    logic [8:0]  frags_seen;
    logic [31:0] stored_len;
    logic [20:0] append_ptr;
    logic [15:0] bracket_depth;
    logic        finished;
    out_beat_t   predicted_stores[$];
    int          errors;

    function new();
      image_mode = 1'b0;
      errors = 0;
      clear();
    endfunction

    function void clear();
      offset = '0;
      header_shift = '0;
      frag_total = 8'(MAX_FRAGMENTS);
      frags_seen = '0;
      stored_len = '0;
      append_ptr = '0;
      bracket_depth = '0;
      finished = 1'b0;
    endfunction

    function void note_byte(in_beat_t b);
      out_beat_t   e;
      logic [7:0]  frag_idx;
      logic [7:0]  total;
      logic [15:0] dlen;
      logic [31:0] ilen;
      logic [31:0] d;
      logic [31:0] a;
      logic [31:0] n;
      logic        keep;
      e = '0;
      if (b.mode == MODE_BEGIN) begin
        clear();
        predicted_stores.push_back(e);
        return;
      end
      if (!finished) begin
        if (image_mode) begin
          if (offset < HEADER_BYTES) header_shift = {header_shift[55:0], b.data_byte};
          frag_idx = header_shift[63:56];
          total = header_shift[55:48];
          dlen = header_shift[47:32];
          ilen = header_shift[31:0];
          if (offset >= HEADER_BYTES) begin
            d = 32'(offset) - HEADER_BYTES;
            if (dlen == 0 || ilen == 0) begin
              a = d;
              keep = 1'b1;
            end else begin
              a = 32'(frag_idx) * FRAGMENT_STRIDE + d;
              keep = d < 32'(dlen);
            end
            if (keep && a < BUFFER_BYTES) begin
              e.write_enable = 1'b1;
              e.write_address = a[19:0];
              e.write_data = b.data_byte;
            end
          end
          if (b.last_byte) begin
            if (32'(offset) + 1 < HEADER_BYTES) begin
              e.status = STATUS_SHORT;
            end else if (dlen == 0 || ilen == 0) begin
              // single unfragmented payload
              n = 32'(offset) + 1 - HEADER_BYTES;
              stored_len = (n > BUFFER_BYTES) ? BUFFER_BYTES : n;
              finished = 1'b1;
            end else begin
              if (frag_idx == 0) frag_total = total;
              if (frags_seen != RCV_FRAG_MAX) frags_seen = frags_seen + 9'd1;
              stored_len = stored_len + 32'(dlen);
              if (frags_seen == {1'b0, frag_total}) begin
                stored_len = ilen;
                finished = 1'b1;
              end
            end
          end
        end else begin
          if (append_ptr < BUFFER_BYTES) begin
            e.write_enable = 1'b1;
            e.write_address = append_ptr[19:0];
            e.write_data = b.data_byte;
            append_ptr = append_ptr + 21'd1;
            if (b.data_byte == CH_OPEN_BRACE || b.data_byte == CH_OPEN_BRACKET)
              bracket_depth = bracket_depth + 16'd1;
            else if (b.data_byte == CH_CLOSE_BRACE || b.data_byte == CH_CLOSE_BRACKET)
              bracket_depth = bracket_depth - 16'd1;
          end
          if (b.last_byte) begin
            if (bracket_depth == 0) begin
              stored_len = 32'(append_ptr);
              finished = 1'b1;
            end else begin
              e.status = STATUS_INCOMPLETE;
            end
          end
        end
        if (b.last_byte) offset = '0;
        else if (offset != POS_MAX) offset = offset + 16'd1;
      end
      e.packet_end = b.last_byte;
      e.complete = finished;
      e.result_length = stored_len;
      predicted_stores.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_store(out_beat_t r);
      out_beat_t e;
      if (predicted_stores.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got 0x%0h", $time, r);
        return;
      end
      e = predicted_stores.pop_front();
      compare_field("write_enable", 32'(e.write_enable), 32'(r.write_enable));
      compare_field("write_address", 32'(e.write_address), 32'(r.write_address));
      compare_field("write_data", 32'(e.write_data), 32'(r.write_data));
      compare_field("packet_end", 32'(e.packet_end), 32'(r.packet_end));
      compare_field("complete", 32'(e.complete), 32'(r.complete));
      compare_field("status", 32'(e.status), 32'(r.status));
      compare_field("result_length", e.result_length, r.result_length);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  logic      cfg_write_enable;
  logic      cfg_write_data;

  store_scoreboard sb;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int beats_sent = 0;
  int stall_cycles = 0;

  fragment_reassembly_writer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_data);
      if (out_valid && out_ready) sb.check_store(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Hold valid and payload until the beat is taken; leave valid high on return.
  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic send_byte(input logic [7:0] value, input logic last);
    in_beat_t b;
    b.mode = MODE_DATA;
    b.data_byte = value;
    b.last_byte = last;
    send_beat(b);
  endtask

  task automatic send_begin();
    in_beat_t b;
    b.mode = MODE_BEGIN;
    b.data_byte = 8'($urandom);
    b.last_byte = 1'($urandom);
    send_beat(b);
  endtask

  task automatic send_noise(input int count);
    int i;
    for (i = 0; i < count; i++) send_byte(8'($urandom), i == count - 1);
  endtask

  // Header goes out big-endian, then plen random payload bytes.
  task automatic send_fragment(input logic [7:0] idx, input logic [7:0] total,
                               input logic [15:0] dlen, input logic [31:0] ilen,
                               input int plen);
    logic [63:0] hdr;
    int i;
    hdr = {idx, total, dlen, ilen};
    for (i = 0; i < HEADER_BYTES + plen; i++)
      send_byte((i < HEADER_BYTES) ? hdr[63 - 8 * i -: 8] : 8'($urandom),
                i == HEADER_BYTES - 1 + plen);
  endtask

  task automatic send_image_response();
    int total;
    int zero_slot;
    int k;
    logic [7:0] idx;
    logic [15:0] dlen;
    send_begin();
    if ($urandom_range(4) == 0) begin
      if ($urandom_range(1))
        send_fragment(8'($urandom), 8'($urandom), 16'h0, $urandom, $urandom_range(0, 12));
      else
        send_fragment(8'($urandom), 8'($urandom), 16'($urandom_range(1, 65535)), 32'h0,
                      $urandom_range(0, 12));
    end else begin
      total = $urandom_range(1, 4);
      zero_slot = $urandom_range(0, total - 1);
      for (k = 0; k < total; k++) begin
        if ($urandom_range(9) == 0) send_noise($urandom_range(1, 10));
        idx = (k == zero_slot) ? 8'h00 : 8'($urandom_range(1, 255));
        dlen = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
        send_fragment(idx, ($urandom_range(15) == 0) ? 8'($urandom) : 8'(total), dlen,
                      $urandom, $urandom_range(0, 8));
      end
    end
    if ($urandom_range(3) == 0) send_noise($urandom_range(1, 4));
  endtask

  task automatic send_text_response();
    logic [7:0] body[$];
    int depth;
    int i;
    int n;
    depth = 0;
    n = $urandom_range(1, 14);
    send_begin();
    for (i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: begin
          body.push_back($urandom_range(1) ? CH_OPEN_BRACE : CH_OPEN_BRACKET);
          depth++;
        end
        1: begin
          if (depth > 0 || $urandom_range(7) == 0) begin
            body.push_back($urandom_range(1) ? CH_CLOSE_BRACE : CH_CLOSE_BRACKET);
            depth--;
          end
        end
        default: body.push_back(8'($urandom));
      endcase
    end
    while (depth > 0) begin
      body.push_back($urandom_range(1) ? CH_CLOSE_BRACE : CH_CLOSE_BRACKET);
      depth--;
    end
    // split into packets at random points
    for (i = 0; i < body.size(); i++)
      send_byte(body[i], (i == body.size() - 1) || ($urandom_range(11) == 0));
    if ($urandom_range(3) == 0) send_noise($urandom_range(1, 4));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.predicted_stores.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_transfer_mode(input logic image);
    drain();
    cfg_write_enable <= 1'b1;
    cfg_write_data <= image;
    sb.image_mode = image;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  initial begin
    int phase;
    int target;
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_write_enable <= 1'b0;
    cfg_write_data <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // image: short packet, fragment with a byte past its data length, then a late byte
    set_transfer_mode(1'b1);
    send_begin();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_fragment(8'h00, 8'h01, 16'h0001, 32'h7, 2);
    send_byte(8'hA5, 1'b1);

    // text: unmatched closer leaves the response open, later packet balances it
    set_transfer_mode(1'b0);
    send_begin();
    send_byte(CH_CLOSE_BRACKET, 1'b1);
    send_byte(CH_OPEN_BRACE, 1'b0);
    send_byte(CH_OPEN_BRACKET, 1'b0);
    send_byte(CH_CLOSE_BRACKET, 1'b0);
    send_byte(CH_CLOSE_BRACE, 1'b0);
    send_byte(CH_OPEN_BRACE, 1'b1);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 49; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 49; end
        default: begin in_idle_pct = 21; out_stall_pct = 21; end
      endcase
      set_transfer_mode(1'b1);
      target = beats_sent + 180;
      while (beats_sent < target) send_image_response();
      set_transfer_mode(1'b0);
      target = beats_sent + 180;
      while (beats_sent < target) send_text_response();
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
